// ===== rtl/dhte_pkg.sv =====
// Shared constants, types and codes for the double-hash table engine.
package dhte_pkg;

   // Table geometry
   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int SIZE_W      = IDX_W + 1;

   // Field widths
   localparam int KEY_W    = 31;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 4;
   localparam int CFG_W    = 5;
   localparam int PROBE_W  = 5;
   localparam int CSR_A_W  = 1;

   // Port widths, padded to whole bytes
   localparam int REQ_DATA_W = 32;
   localparam int REQ_USER_W = 8;
   localparam int RSP_DATA_W = 8;
   localparam int RSP_USER_W = 8;

   // Secondary hash prime
   localparam int HASH_PRIME = 5;
   localparam int PRIME_W    = 3;

   // Configuration defaults
   localparam logic [CFG_W-1:0]   TABLE_SIZE_RST  = CFG_W'(16);
   localparam logic [PROBE_W-1:0] PROBE_LIMIT_RST = PROBE_W'(16);

   // Register indexes
   localparam logic [CSR_A_W-1:0] CSR_TABLE_SIZE  = 1'b0;
   localparam logic [CSR_A_W-1:0] CSR_PROBE_LIMIT = 1'b1;

   // Operation codes; the unused code behaves as a lookup
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      STS_INSERTED  = 3'd0,
      STS_DUPLICATE = 3'd1,
      STS_NO_SLOT   = 3'd2,
      STS_REMOVED   = 3'd3,
      STS_NOT_FOUND = 3'd4,
      STS_FOUND     = 3'd5
   } status_type;

   // Where the reported slot number comes from
   typedef enum logic [1:0] {
      SRC_ZERO  = 2'd0,
      SRC_HIT   = 2'd1,
      SRC_PROBE = 2'd2,
      SRC_TOMB  = 2'd3
   } src_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'd0,
      ST_SCAN   = 3'd1,
      ST_STEP   = 3'd2,
      ST_PROBE  = 3'd3,
      ST_FINISH = 3'd4,
      ST_RESP   = 3'd5
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic       start;
      logic       step_load;
      logic       probe_next;
      logic       tomb_take;
      logic       write;
      logic       write_tomb;
      logic       remove;
      logic       res_set;
      status_type res_status;
      src_type    res_src;
      logic       rsp_load;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic            scan_done;
      logic            mod_done;
      logic            hit;
      logic [OP_W-1:0] op;
      logic            used_h;
      logic            del_h;
      logic            have_tomb;
      logic            probe_last;
      logic            limit_zero;
      logic            out_free;
   } sts_type;

endpackage

// ===== rtl/double_hash_table_engine.sv =====
// Top level of the double-hash table engine: controller, datapath and checks.
//
//   Channel   Direction  Handshake               Payload
//   req_*     in         req_tvalid/req_tready   tuser: op; tdata: key
//   rsp_*     out        rsp_tvalid/rsp_tready   tuser: status; tdata: slot_index
//   csr_*     in         csr_we                  csr_addr: register, csr_wdata: value
//
// A request scans the S slots of the effective table size and, alongside, runs the
// bit-serial remainder unit, two key bits a cycle; the controller waits for both.
// An insert that misses then loads the stride and probes one slot per cycle up to
// probe_limit; a never-used slot ends the walk, else a finish step uses the first
// tombstone, if any. The result loads once the output register is free.
// Reset clears all slot flags at once and sets both registers to 16.
// A result waiting in the output register does not block the next request; the block
// holds that next result until the output register is free.
module double_hash_table_engine (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [dhte_pkg::REQ_DATA_W-1:0]     req_tdata,  // [30:0] key
   input  logic [dhte_pkg::REQ_USER_W-1:0]     req_tuser,  // [1:0] op
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [dhte_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // [3:0] slot_index
   output logic [dhte_pkg::RSP_USER_W-1:0]     rsp_tuser,  // [2:0] status
   input  logic                                csr_we,
   input  logic [dhte_pkg::CSR_A_W-1:0]        csr_addr,
   input  logic [dhte_pkg::CFG_W-1:0]          csr_wdata
);
   import dhte_pkg::*;

   cmd_type cmd;
   sts_type sts;

   dhte_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   dhte_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // A new request cannot produce a result in the very next cycle.
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !$rose(rsp_tvalid))
      else $error("result raised one cycle after a request");

   // A slot is never written and freed in the same cycle.
   a_write_remove_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.write && cmd.remove))
      else $error("slot write and remove collide");

   // Misses report slot zero.
   a_miss_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser[2:0] == STS_NOT_FOUND || rsp_tuser[2:0] == STS_NO_SLOT))
      |-> (rsp_tdata == '0))
      else $error("miss result carries a nonzero slot");

   // A result is only loaded while the output register is free.
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_tvalid || rsp_tready))
      else $error("result overwritten before it was taken");

endmodule

// ===== rtl/dhte_ctrl.sv =====
// Controller state machine that sequences scan, hashing, probing and response.
module dhte_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  dhte_pkg::sts_type sts,
   output dhte_pkg::cmd_type cmd
);
   import dhte_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next-state logic
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (sts.scan_done && sts.mod_done) begin
               if (sts.op == OP_INSERT && !sts.hit) state_in = ST_STEP;
               else state_in = ST_RESP;
            end
         end
         ST_STEP: begin
            if (sts.limit_zero) state_in = ST_FINISH;
            else state_in = ST_PROBE;
         end
         ST_PROBE: begin
            if (!sts.used_h && !sts.del_h) state_in = ST_RESP;
            else if (sts.probe_last) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Output logic
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.start  = req_tvalid;
         end
         ST_SCAN: begin
            if (sts.scan_done && sts.mod_done) begin
               priority if (sts.op == OP_INSERT) begin
                  // A stored key is reported as a duplicate.
                  if (sts.hit) begin
                     cmd.res_set    = 1'b1;
                     cmd.res_status = STS_DUPLICATE;
                     cmd.res_src    = SRC_HIT;
                  end
               end else if (sts.op == OP_REMOVE) begin
                  cmd.res_set = 1'b1;
                  if (sts.hit) begin
                     cmd.remove     = 1'b1;
                     cmd.res_status = STS_REMOVED;
                     cmd.res_src    = SRC_HIT;
                  end else begin
                     cmd.res_status = STS_NOT_FOUND;
                     cmd.res_src    = SRC_ZERO;
                  end
               end else begin
                  cmd.res_set = 1'b1;
                  if (sts.hit) begin
                     cmd.res_status = STS_FOUND;
                     cmd.res_src    = SRC_HIT;
                  end else begin
                     cmd.res_status = STS_NOT_FOUND;
                     cmd.res_src    = SRC_ZERO;
                  end
               end
            end
         end
         ST_STEP: begin
            cmd.step_load = 1'b1;
         end
         ST_PROBE: begin
            if (!sts.used_h && !sts.del_h) begin
               // A never-used slot ends the probe at once.
               cmd.write      = 1'b1;
               cmd.res_set    = 1'b1;
               cmd.res_status = STS_INSERTED;
               cmd.res_src    = SRC_PROBE;
            end else begin
               if (!sts.used_h && !sts.have_tomb) cmd.tomb_take = 1'b1;
               cmd.probe_next = !sts.probe_last;
            end
         end
         ST_FINISH: begin
            cmd.res_set = 1'b1;
            if (sts.have_tomb) begin
               cmd.write      = 1'b1;
               cmd.write_tomb = 1'b1;
               cmd.res_status = STS_INSERTED;
               cmd.res_src    = SRC_TOMB;
            end else begin
               cmd.res_status = STS_NO_SLOT;
               cmd.res_src    = SRC_ZERO;
            end
         end
         ST_RESP: begin
            cmd.rsp_load = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== rtl/dhte_dp.sv =====
// Datapath: slot store, key scan, bit-serial hashing, probe walk and result register.
module dhte_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  dhte_pkg::cmd_type                   cmd,
   output dhte_pkg::sts_type                   sts,
   input  logic [dhte_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [dhte_pkg::REQ_USER_W-1:0]     req_tuser,
   input  logic                                csr_we,
   input  logic [dhte_pkg::CSR_A_W-1:0]        csr_addr,
   input  logic [dhte_pkg::CFG_W-1:0]          csr_wdata,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic [dhte_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [dhte_pkg::RSP_USER_W-1:0]     rsp_tuser
);
   import dhte_pkg::*;

   localparam int MOD_BITS  = KEY_W + (KEY_W % 2);
   localparam int MOD_STEPS = MOD_BITS / 2;
   localparam int MCNT_W    = $clog2(MOD_STEPS + 1);
   localparam int NSUM_W    = 7;
   localparam int FOLD_W    = 5;

   // One restoring step of a remainder by a small divisor, two bits at a time.
   function automatic logic [SIZE_W-1:0] mod_size2(input logic [SIZE_W-1:0] r,
                                                   input logic [1:0] b,
                                                   input logic [SIZE_W-1:0] d);
      logic [SIZE_W:0] t;
      t = {r, b[1]};
      if (t >= {1'b0, d}) t = t - {1'b0, d};
      t = {t[SIZE_W-1:0], b[0]};
      if (t >= {1'b0, d}) t = t - {1'b0, d};
      return t[SIZE_W-1:0];
   endfunction

   // Sum of the key's hex digits; sixteen leaves one modulo the prime.
   function automatic logic [NSUM_W-1:0] nibble_sum(input logic [KEY_W-1:0] k);
      logic [NSUM_W-1:0] s;
      s = NSUM_W'(k[3:0]) + NSUM_W'(k[7:4]) + NSUM_W'(k[11:8]) + NSUM_W'(k[15:12])
        + NSUM_W'(k[19:16]) + NSUM_W'(k[23:20]) + NSUM_W'(k[27:24])
        + NSUM_W'(k[30:28]);
      return s;
   endfunction

   // Folds the digit sum twice more, then brings it below the prime.
   function automatic logic [PRIME_W-1:0] fold_prime(input logic [NSUM_W-1:0] s);
      logic [FOLD_W-1:0] f1;
      logic [FOLD_W-1:0] f2;
      f1 = FOLD_W'(s[3:0]) + FOLD_W'(s[NSUM_W-1:4]);
      f2 = FOLD_W'(f1[3:0]) + FOLD_W'(f1[FOLD_W-1]);
      if (f2 >= FOLD_W'(2 * HASH_PRIME)) f2 = f2 - FOLD_W'(2 * HASH_PRIME);
      if (f2 >= FOLD_W'(HASH_PRIME)) f2 = f2 - FOLD_W'(HASH_PRIME);
      return f2[PRIME_W-1:0];
   endfunction

   // Probe stride reduced below the table size; the stride is at most the prime.
   function automatic logic [SIZE_W-1:0] stride_mod(input logic [PRIME_W-1:0] r5,
                                                   input logic [SIZE_W-1:0] d);
      logic [SIZE_W-1:0] s;
      s = SIZE_W'(PRIME_W'(HASH_PRIME) - r5);
      for (int k = 0; k < HASH_PRIME; k++) begin
         if (s >= d) s = s - d;
      end
      return s;
   endfunction

   // Configuration registers
   logic [CFG_W-1:0]   table_size_ff;
   logic [PROBE_W-1:0] probe_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff  <= TABLE_SIZE_RST;
         probe_limit_ff <= PROBE_LIMIT_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_TABLE_SIZE:  table_size_ff  <= csr_wdata;
            CSR_PROBE_LIMIT: probe_limit_ff <= PROBE_W'(csr_wdata);
            default: ;
         endcase
      end
   end

   // Effective table size, clamped to one and the depth
   logic [SIZE_W-1:0] size_eff_in;

   always_comb begin
      if (table_size_ff == '0) size_eff_in = SIZE_W'(1);
      else if (32'(table_size_ff) > TABLE_DEPTH) size_eff_in = SIZE_W'(TABLE_DEPTH);
      else size_eff_in = SIZE_W'(table_size_ff);
   end

   // Request capture
   logic [KEY_W-1:0]  key_ff;
   logic [OP_W-1:0]   op_ff;
   logic [SIZE_W-1:0] size_eff_ff;

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         key_ff      <= req_tdata[KEY_W-1:0];
         op_ff       <= req_tuser[OP_W-1:0];
         size_eff_ff <= size_eff_in;
      end
   end

   // Slot flags, cleared at reset
   logic [TABLE_DEPTH-1:0] used_ff;
   logic [TABLE_DEPTH-1:0] del_ff;
   logic [IDX_W-1:0]       h_ff;
   logic [IDX_W-1:0]       tomb_ff;
   logic [IDX_W-1:0]       hit_idx_ff;
   logic [IDX_W-1:0]       waddr;

   assign waddr = cmd.write_tomb ? tomb_ff : h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         del_ff  <= '0;
      end else if (cmd.write) begin
         used_ff[waddr] <= 1'b1;
      end else if (cmd.remove) begin
         used_ff[hit_idx_ff] <= 1'b0;
         del_ff[hit_idx_ff]  <= 1'b1;
      end
   end

   // Key store with a registered read port for the scan
   logic [KEY_W-1:0]  slot_mem [TABLE_DEPTH];
   logic [KEY_W-1:0]  rd_data_ff;
   logic [SIZE_W-1:0] scan_ff;

   always_ff @(posedge clock) begin
      if (cmd.write) slot_mem[waddr] <= key_ff;
      rd_data_ff <= slot_mem[scan_ff[IDX_W-1:0]];
   end

   // Scan pipeline: issue one slot a cycle, compare it in the following cycle
   logic             scan_issue;
   logic             cmp_vld_ff;
   logic [IDX_W-1:0] cmp_idx_ff;
   logic             hit_ff;

   assign scan_issue = (scan_ff < size_eff_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff    <= '0;
         cmp_vld_ff <= 1'b0;
         hit_ff     <= 1'b0;
      end else if (cmd.start) begin
         scan_ff    <= '0;
         cmp_vld_ff <= 1'b0;
         hit_ff     <= 1'b0;
      end else begin
         cmp_vld_ff <= scan_issue;
         if (scan_issue) scan_ff <= scan_ff + SIZE_W'(1);
         if (cmp_vld_ff && !hit_ff && used_ff[cmp_idx_ff] && rd_data_ff == key_ff) begin
            hit_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= scan_ff[IDX_W-1:0];
      if (cmp_vld_ff && !hit_ff && used_ff[cmp_idx_ff] && rd_data_ff == key_ff) begin
         hit_idx_ff <= cmp_idx_ff;
      end
   end

   // Bit-serial remainder by the table size
   logic [MCNT_W-1:0]   mod_cnt_ff;
   logic [MOD_BITS-1:0] kshift_ff;
   logic [SIZE_W-1:0]   rsize_ff;
   logic [PRIME_W-1:0]  rprime_ff;
   logic [NSUM_W-1:0]   nsum_ff;
   logic                mod_busy;

   assign mod_busy = (mod_cnt_ff != MCNT_W'(MOD_STEPS));

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_cnt_ff <= MCNT_W'(MOD_STEPS);
      end else if (cmd.start) begin
         mod_cnt_ff <= '0;
      end else if (mod_busy) begin
         mod_cnt_ff <= mod_cnt_ff + MCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         kshift_ff <= MOD_BITS'(req_tdata[KEY_W-1:0]);
         rsize_ff  <= '0;
      end else if (mod_busy) begin
         kshift_ff <= {kshift_ff[MOD_BITS-3:0], 2'b00};
         rsize_ff  <= mod_size2(rsize_ff, kshift_ff[MOD_BITS-1 -: 2], size_eff_ff);
      end
   end

   // Remainder by the prime in two register stages; it settles long before the stride load.
   always_ff @(posedge clock) begin
      nsum_ff   <= nibble_sum(key_ff);
      rprime_ff <= fold_prime(nsum_ff);
   end

   // Probe walk: position, stride, count and first tombstone
   logic [SIZE_W-1:0]  stride_ff;
   logic [PROBE_W-1:0] probe_i_ff;
   logic               have_tomb_ff;
   logic [SIZE_W:0]    h_sum;
   logic [SIZE_W:0]    h_wrap;

   assign h_sum  = (SIZE_W+1)'(h_ff) + (SIZE_W+1)'(stride_ff);
   assign h_wrap = (h_sum >= (SIZE_W+1)'(size_eff_ff)) ?
                   h_sum - (SIZE_W+1)'(size_eff_ff) : h_sum;

   always_ff @(posedge clock) begin
      if (cmd.step_load) begin
         h_ff       <= rsize_ff[IDX_W-1:0];
         stride_ff  <= stride_mod(rprime_ff, size_eff_ff);
         probe_i_ff <= '0;
      end else if (cmd.probe_next) begin
         h_ff       <= h_wrap[IDX_W-1:0];
         probe_i_ff <= probe_i_ff + PROBE_W'(1);
      end
      if (cmd.tomb_take) tomb_ff <= h_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_tomb_ff <= 1'b0;
      end else if (cmd.start) begin
         have_tomb_ff <= 1'b0;
      end else if (cmd.tomb_take) begin
         have_tomb_ff <= 1'b1;
      end
   end

   // Pending result, then the output register
   status_type       res_status_ff;
   logic [IDX_W-1:0] res_slot_ff;
   logic [IDX_W-1:0] res_slot_in;
   logic             rsp_tvalid_ff;
   status_type       rsp_status_ff;
   logic [SLOT_W-1:0] rsp_slot_ff;

   always_comb begin
      unique case (cmd.res_src)
         SRC_ZERO:  res_slot_in = '0;
         SRC_HIT:   res_slot_in = hit_idx_ff;
         SRC_PROBE: res_slot_in = h_ff;
         SRC_TOMB:  res_slot_in = tomb_ff;
         default:   res_slot_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.res_set) begin
         res_status_ff <= cmd.res_status;
         res_slot_ff   <= res_slot_in;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_slot_ff   <= SLOT_W'(res_slot_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_slot_ff);
   assign rsp_tuser  = RSP_USER_W'(rsp_status_ff);

   // Status toward the controller
   always_comb begin
      sts            = '0;
      sts.scan_done  = !scan_issue && !cmp_vld_ff;
      sts.mod_done   = !mod_busy;
      sts.hit        = hit_ff;
      sts.op         = op_ff;
      sts.used_h     = used_ff[h_ff];
      sts.del_h      = del_ff[h_ff];
      sts.have_tomb  = have_tomb_ff;
      sts.probe_last = (probe_i_ff == (probe_limit_ff - PROBE_W'(1)));
      sts.limit_zero = (probe_limit_ff == '0);
      sts.out_free   = !rsp_tvalid_ff || rsp_tready;
   end

endmodule
